// File: rtl/core/alma_pkg.sv
// ----------------------------------------------------------------------------
// Level meter package
// Shared payload types and constants of the level meter aggregator.
// ----------------------------------------------------------------------------
package alma_pkg;

  localparam int unsigned SrW = 19;
  localparam int unsigned SpW = 21;
  localparam int unsigned TsW = 40;
  localparam int unsigned DbW = 16;

  localparam logic signed [DbW-1:0] DbFloor = -16'sd25600;
  localparam logic signed [DbW-1:0] DbCeil  = 16'sd6400;
  localparam logic [19:0] KPower = 20'd197283;
  localparam logic [19:0] KAmpl  = 20'd394566;

  typedef struct packed {
    logic [39:0] timestamp;
    logic [15:0] sample_count;
    logic [47:0] square_sum;
    logic [15:0] peak_level;
  } in_word_t;

  typedef struct packed {
    logic [39:0]        duration;
    logic               totals_valid;
    logic signed [15:0] total_rms_db;
    logic signed [15:0] peak_db;
    logic signed [15:0] crest_db;
    logic               point_valid;
    logic [39:0]        point_time;
    logic signed [15:0] point_rms_db;
    logic signed [15:0] point_peak_db;
  } out_word_t;

  // Request to the shared log2 unit.
  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } log_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] result;  // log2 in unsigned Q6.24 (value >= 1)
  } log_rsp_t;

endpackage

// File: rtl/core/alma_log2.sv
// ----------------------------------------------------------------------------
// Iterative log2 unit
// Computes log2 of a 64-bit value in Q6.24, one squaring per cycle.
// ----------------------------------------------------------------------------
module alma_log2 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alma_pkg::log_req_t req_i,
  output alma_pkg::log_rsp_t rsp_o
);

  logic [5:0]  exp_c;
  logic [31:0] mant_c;
  logic [32:0] mant_q, mant_d;
  logic [65:0] sq;
  logic [34:0] sq_sh;
  logic [30:0] res_q, res_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  // Priority encoder for the top set bit (value zero maps to exponent zero).
  always_comb begin
    exp_c = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (req_i.value[i]) exp_c = 6'(i);
    end
  end

  assign mant_c = (exp_c > 6'd31) ? 32'(req_i.value >> (exp_c - 6'd31))
                                  : 32'(req_i.value << (6'd31 - exp_c));
  assign sq     = 66'(mant_q) * 66'(mant_q);
  assign sq_sh  = sq[65:31];

  always_comb begin
    mant_d = mant_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      mant_d = {1'b0, mant_c};
      res_d  = {1'b0, exp_c, 24'd0};
      cnt_d  = 5'd23;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sq_sh[32]) begin
        mant_d = sq_sh[33:1];
        res_d  = res_q | (31'd1 << cnt_q);
      end else begin
        mant_d = sq_sh[32:0];
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q <= mant_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("log2 done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == 5'd23)
    else $error("log2 did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == 5'd0 |=> done_q)
    else $error("log2 did not finish");

endmodule

// File: rtl/core/alma_div.sv
// ----------------------------------------------------------------------------
// Block length divider
// Restoring divider, one quotient bit per cycle, for count*65536/rate.
// ----------------------------------------------------------------------------
module alma_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [18:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [31:0] num_q, num_d;
  logic [18:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [18:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [19:0] trial;

  assign trial = {rem_q, num_q[31]};

  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = 6'd31; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 19'(trial - {1'b0, den_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[18:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/audio_level_meter_aggregator_core.sv
// ----------------------------------------------------------------------------
// Audio level meter aggregator
// Integrated RMS, peak and crest in dB, with spaced timeline points.
// ----------------------------------------------------------------------------
// Usage: an input word (timestamp, sample count, square sum, peak) is taken
// when in_valid_i is high and in_stall_o low. Each input word yields exactly
// one output word on out_valid_o, held until out_stall_i is low.
// Configuration writes (index 0 sample rate, index 1 timeline spacing) use
// cfg_valid_i/cfg_ready_o and are taken only while the block is idle; the
// input is stalled in any cycle in which a configuration write is offered.
// Processing: after an input word is taken, a first step folds it into the
// totals. The shared log2 unit then runs six passes (total power, total
// samples, largest peak, block power, block count, block peak), whose results
// feed four dB multiply and round steps; a final step builds the output word.
// The block length divider runs alongside the log2 passes, and the output
// word waits for its result. Only one word is in flight: the next input word
// is taken only after the output word has been released.
// At reset all totals clear, the registers take 48000 Hz and 0.25 s, and the
// next word always makes a timeline point. A stalled receiver simply holds
// the output word; no further input is taken meanwhile.
// ----------------------------------------------------------------------------
module audio_level_meter_aggregator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  alma_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output alma_pkg::out_word_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StLogTs, StLogTn, StLogPs, StLogPc, StLogMp, StLogPk,
    StDb, StDone, StOut
  } state_e;

  localparam logic [0:0] RegRate = 1'b0;
  localparam logic [0:0] RegSpacing = 1'b1;

  state_e state_q, ret_q;
  logic [18:0] rate_q;
  logic [20:0] spacing_q;
  logic [39:0] dur_q, last_q;
  logic [63:0] tsq_q;
  logic [47:0] tsmp_q;
  logic [15:0] mpk_q;
  logic        first_q;
  alma_pkg::in_word_t in_q;
  alma_pkg::out_word_t out_q;
  logic        point_q;
  logic [30:0] lga_q;          // first operand log of a ratio
  logic signed [32:0] lg_q;    // signed log for dB conversion
  logic [19:0] k_q;
  logic [2:0]  slot_q;         // which dB value is being produced
  logic        div_done_q;
  logic [31:0] len_q;
  logic        start_q;

  alma_pkg::log_req_t lreq;
  alma_pkg::log_rsp_t lrsp;
  logic        div_start, div_done;
  logic [31:0] div_quo;
  logic        in_take;
  logic        fold;

  logic [64:0] sq_sum;
  logic [48:0] smp_sum;
  logic [40:0] end_t, next_pt;
  logic signed [53:0] prod;
  logic signed [53:0] rnd;
  logic signed [21:0] dbr;
  logic signed [15:0] dbc;

  alma_log2 u_log2 (.clk_i, .rst_ni, .req_i(lreq), .rsp_o(lrsp));
  alma_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({in_data_i.sample_count, 16'd0}), .den_i(rate_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign in_stall_o  = (state_q != StIdle) || cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;
  assign in_take     = in_valid_i && !in_stall_o;

  // The first cycle after acceptance folds the word into the totals.
  assign fold = (state_q == StLogTs) && !start_q && (slot_q == 3'd0) && (ret_q == StIdle);

  assign sq_sum  = {1'b0, tsq_q} + 65'(in_q.square_sum);
  assign smp_sum = {1'b0, tsmp_q} + 49'(in_q.sample_count);
  assign end_t   = {1'b0, in_q.timestamp}
                   + ((in_q.sample_count != 16'd0 && rate_q != '0) ? 41'(len_q) : 41'd0);
  assign next_pt = {1'b0, last_q} + 41'(spacing_q);

  // dB conversion: log (Q.24) times constant (Q.16), round to Q8.8, clamp.
  assign prod = 54'(lg_q) * $signed({1'b0, 34'(k_q)});
  assign rnd  = (prod + 54'sd2147483648) >>> 32;
  assign dbr  = 22'(rnd);
  assign dbc  = (dbr < 22'(alma_pkg::DbFloor)) ? alma_pkg::DbFloor :
                (dbr > 22'(alma_pkg::DbCeil)) ? alma_pkg::DbCeil : 16'(dbr);

  // Start pulses are generated on state entry through the start flag.
  always_comb begin
    lreq.start = start_q;
    lreq.value = '0;
    case (state_q)
      StLogTn: lreq.value = 64'(tsmp_q);
      StLogPc: lreq.value = (in_q.sample_count == 16'd0) ? 64'd1
                                                         : 64'(in_q.sample_count);
      StLogPs: lreq.value = 64'(in_q.square_sum);
      StLogPk: lreq.value = 64'(in_q.peak_level);
      StLogMp: lreq.value = 64'(mpk_q);
      default: lreq.value = tsq_q;
    endcase
  end

  assign div_start = in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ret_q      <= StIdle;
      rate_q     <= 19'd48000;
      spacing_q  <= 21'd16384;
      dur_q      <= '0;
      last_q     <= '0;
      tsq_q      <= '0;
      tsmp_q     <= '0;
      mpk_q      <= '0;
      first_q    <= 1'b1;
      start_q    <= 1'b0;
      div_done_q <= 1'b0;
      slot_q     <= '0;
      in_q       <= '0;
      out_q      <= '0;
      point_q    <= 1'b0;
      lga_q      <= '0;
      lg_q       <= '0;
      k_q        <= '0;
    end else begin
      start_q <= fold || ((state_q == StLogTs) && lrsp.done)
                 || ((state_q == StLogPs) && lrsp.done)
                 || ((state_q == StDb) && (ret_q != StDone));
      if (in_take) begin
        div_done_q <= 1'b0;
      end else if (div_done) begin
        div_done_q <= 1'b1;
      end
      case (state_q)
        StIdle: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == RegRate) begin
              rate_q <= cfg_data_i[18:0];
            end else if (cfg_index_i == RegSpacing) begin
              spacing_q <= cfg_data_i[20:0];
            end
          end
          if (in_take) begin
            in_q       <= in_data_i;
            state_q    <= StLogTs;
            // Totals update first; logs then read the new totals.
          end
        end
        StLogTs: begin
          if (fold) begin
            tsq_q   <= sq_sum[64] ? '1 : sq_sum[63:0];
            tsmp_q  <= smp_sum[48] ? '1 : smp_sum[47:0];
            if (in_q.peak_level > mpk_q) mpk_q <= in_q.peak_level;
            point_q <= first_q || ({1'b0, in_q.timestamp} >= next_pt);
            ret_q   <= StLogTs;
          end else if (lrsp.done) begin
            lga_q   <= lrsp.result;
            state_q <= StLogTn;
          end
        end
        StLogTn: if (lrsp.done) begin
          lg_q    <= $signed({2'b0, lga_q}) - $signed(33'(32'd32 << 24))
                     - $signed({2'b0, lrsp.result});
          k_q     <= alma_pkg::KPower;
          slot_q  <= 3'd1;
          ret_q   <= StLogMp;
          state_q <= StDb;
        end
        StLogMp: if (lrsp.done) begin
          lg_q    <= $signed({2'b0, lrsp.result}) - $signed(33'(32'd12 << 24));
          k_q     <= alma_pkg::KAmpl;
          slot_q  <= 3'd2;
          ret_q   <= StLogPs;
          state_q <= StDb;
        end
        StLogPs: if (lrsp.done) begin
          lga_q   <= lrsp.result;
          state_q <= StLogPc;
        end
        StLogPc: if (lrsp.done) begin
          lg_q    <= $signed({2'b0, lga_q}) - $signed(33'(32'd32 << 24))
                     - $signed({2'b0, lrsp.result});
          k_q     <= alma_pkg::KPower;
          slot_q  <= 3'd3;
          ret_q   <= StLogPk;
          state_q <= StDb;
        end
        StLogPk: if (lrsp.done) begin
          lg_q    <= $signed({2'b0, lrsp.result}) - $signed(33'(32'd12 << 24));
          k_q     <= alma_pkg::KAmpl;
          slot_q  <= 3'd4;
          ret_q   <= StDone;
          state_q <= StDb;
        end
        StDb: begin
          case (slot_q)
            3'd1: out_q.total_rms_db <= (tsq_q == '0) ? alma_pkg::DbFloor : dbc;
            3'd2: out_q.peak_db <= (mpk_q == '0) ? alma_pkg::DbFloor : dbc;
            3'd3: out_q.point_rms_db <=
                    (in_q.square_sum == '0) ? alma_pkg::DbFloor : dbc;
            default: out_q.point_peak_db <=
                    (in_q.peak_level == '0) ? alma_pkg::DbFloor : dbc;
          endcase
          state_q <= ret_q;
        end
        StDone: if (div_done_q) begin
          if (end_t[39:0] > dur_q || end_t[40]) begin
            dur_q <= end_t[40] ? '1 : end_t[39:0];
            out_q.duration <= end_t[40] ? '1 : end_t[39:0];
          end else begin
            out_q.duration <= dur_q;
          end
          out_q.totals_valid <= (tsmp_q != '0);
          if (tsmp_q == '0) begin
            out_q.total_rms_db <= '0;
            out_q.peak_db      <= '0;
            out_q.crest_db     <= '0;
          end else begin
            out_q.crest_db <= out_q.peak_db - out_q.total_rms_db;
          end
          out_q.point_valid <= point_q;
          out_q.point_time  <= point_q ? in_q.timestamp : '0;
          if (!point_q) begin
            out_q.point_rms_db  <= '0;
            out_q.point_peak_db <= '0;
          end else begin
            first_q <= 1'b0;
            last_q  <= in_q.timestamp;
          end
          state_q <= StOut;
        end
        StOut: if (!out_stall_i) begin
          state_q <= StIdle;
          ret_q   <= StIdle;
          slot_q  <= '0;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) len_q <= div_quo;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while output pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) && !out_stall_i |=> state_q == StIdle)
    else $error("output not released");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) && div_done_q |=> out_valid_o)
    else $error("result not presented");

endmodule
